>>> src/vmm_pkg.sv
// shared types and constants for the vector matrix multiply block
package vmm_pkg;

  // fixed field widths
  localparam int ROW_IDX_W  = 6;
  localparam int COL_IDX_W  = 5;
  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 6;
  // width that holds any column count up to the largest column parameter
  localparam int CNT_COL_W  = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 7'd64;
  localparam logic [COLS_CFG_W-1:0] COLS_RST = 6'd32;

  // largest result run
  localparam int RESULT_CAP = 32;

  // input action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_MATRIX = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [ROW_IDX_W-1:0]     row_index;
    logic [COL_IDX_W-1:0]     col_index;
    logic signed [ELEM_W-1:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic [COL_IDX_W-1:0]    column;
    logic signed [ACC_W-1:0] column_sum;
    logic                    last_result;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_EREAD,
    ST_EOUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic vec_wr;
    logic cap_in;
    logic mul_en;
    logic acc_wr;
    logic emit_sel;
    logic k_clr;
    logic k_inc;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_load;
    logic in_mac;
    logic last_elem;
    logic k_last;
  } status_t;

endpackage

>>> src/vmm_ram.sv
// generic single write port ram with registered read
module vmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/vmm_ctrl.sv
// controller state machine for the vector matrix multiply block
module vmm_ctrl
  import vmm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (st.in_load) begin
            cmd.vec_wr = 1'b1;
          end else if (st.in_mac) begin
            cmd.cap_in = 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_wr = 1'b1;
        if (st.last_elem) begin
          cmd.k_clr = 1'b1;
          state_nxt = ST_EREAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EREAD: begin
        cmd.emit_sel = 1'b1;
        state_nxt    = ST_EOUT;
      end
      ST_EOUT: begin
        cmd.emit_sel = 1'b1;
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          if (st.k_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = ST_EREAD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/vmm_dp.sv
// datapath: config registers, vector store, multiplier and column accumulators
module vmm_dp
  import vmm_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               st,
  input  in_word_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_word_t             out_data
);

  localparam int RCW     = ($clog2(MAX_ROWS + 1) > ROWS_CFG_W) ?
                           $clog2(MAX_ROWS + 1) : ROWS_CFG_W;
  localparam int RAW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int COL_CAP = (MAX_COLS < RESULT_CAP) ? MAX_COLS : RESULT_CAP;

  logic [ROWS_CFG_W-1:0] rows_in_use_r;
  logic [COLS_CFG_W-1:0] cols_in_use_r;

  logic [RCW-1:0]       rows_ext, eff_rows;
  logic [CNT_COL_W-1:0] cols_ext, eff_cols;

  logic [ROW_IDX_W-1:0]     row_r;
  logic [COL_IDX_W-1:0]     col_r;
  logic signed [ELEM_W-1:0] val_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [AW-1:0]            k_r;
  logic [MAX_COLS-1:0]      acc_vld_r;
  out_word_t                out_data_r;

  logic [RCW-1:0]           in_row_ext, row_ext_r;
  logic [CNT_COL_W-1:0]     in_col_ext, col_ext_r, k_ext;
  logic signed [ELEM_W-1:0] vec_rdata;
  logic [ACC_W-1:0]         acc_rdata;
  logic signed [ACC_W-1:0]  acc_old, acc_sum;
  logic [AW-1:0]            col_addr, acc_raddr;
  logic                     vec_we;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RST;
      cols_in_use_r <= COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_IN_USE: rows_in_use_r <= cfg_data[ROWS_CFG_W-1:0];
        REG_COLS_IN_USE: cols_in_use_r <= cfg_data[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes into range
  always_comb begin
    rows_ext = RCW'(rows_in_use_r);
    if (rows_ext == '0) begin
      eff_rows = RCW'(1);
    end else if (rows_ext > RCW'(MAX_ROWS)) begin
      eff_rows = RCW'(MAX_ROWS);
    end else begin
      eff_rows = rows_ext;
    end
    cols_ext = CNT_COL_W'(cols_in_use_r);
    if (cols_ext == '0) begin
      eff_cols = CNT_COL_W'(1);
    end else if (cols_ext > CNT_COL_W'(COL_CAP)) begin
      eff_cols = CNT_COL_W'(COL_CAP);
    end else begin
      eff_cols = cols_ext;
    end
  end

  assign in_row_ext = RCW'(in_data.row_index);
  assign in_col_ext = CNT_COL_W'(in_data.col_index);
  assign row_ext_r  = RCW'(row_r);
  assign col_ext_r  = CNT_COL_W'(col_r);
  assign k_ext      = CNT_COL_W'(k_r);

  assign st.in_load   = (in_data.action == ACT_LOAD);
  assign st.in_mac    = (in_data.action == ACT_MATRIX) && (in_row_ext < eff_rows) &&
                        (in_col_ext < eff_cols);
  assign st.last_elem = (row_ext_r == eff_rows - RCW'(1)) &&
                        (col_ext_r == eff_cols - CNT_COL_W'(1));
  assign st.k_last    = (k_ext == eff_cols - CNT_COL_W'(1));

  // vector store
  assign vec_we = cmd.vec_wr && (in_row_ext < RCW'(MAX_ROWS));

  vmm_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(MAX_ROWS)
  ) u_vec_ram (
    .clk  (clk),
    .we   (vec_we),
    .waddr(in_row_ext[RAW-1:0]),
    .wdata(in_data.element_value),
    .raddr(row_ext_r[RAW-1:0]),
    .rdata(vec_rdata)
  );

  // column accumulators, valid bit clear reads as zero
  assign col_addr  = col_ext_r[AW-1:0];
  assign acc_raddr = cmd.emit_sel ? k_r : col_addr;
  assign acc_old   = acc_vld_r[acc_raddr] ? acc_rdata : '0;
  assign acc_sum   = acc_old + ACC_W'(prod_r);

  vmm_ram #(
    .WIDTH(ACC_W),
    .DEPTH(MAX_COLS)
  ) u_acc_ram (
    .clk  (clk),
    .we   (cmd.acc_wr),
    .waddr(col_addr),
    .wdata(acc_sum),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (cmd.acc_wr) begin
      acc_vld_r[col_addr] <= 1'b1;
    end else if (cmd.out_load) begin
      acc_vld_r[k_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + AW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      row_r <= in_data.row_index;
      col_r <= in_data.col_index;
      val_r <= in_data.element_value;
    end
    if (cmd.mul_en) begin
      prod_r <= vec_rdata * val_r;
    end
    if (cmd.out_load) begin
      out_data_r.column      <= k_ext[COL_IDX_W-1:0];
      out_data_r.column_sum  <= acc_old;
      out_data_r.last_result <= st.k_last;
    end
  end

  assign out_data = out_data_r;

endmodule

>>> src/vector_matrix_multiply.sv
// top level of the fixed point row vector times matrix block
//
// load words (action 0) write one Q8.8 vector element into the vector store; a
// vector element must be loaded before any matrix word uses its row. matrix
// words (action 1) come in row-major order; each adds vector[row] * element
// into its column's 40-bit accumulator and passes through accept, vector and
// accumulator read, multiply and accumulate in turn, set by the registered-read
// memories and the single multiplier; no new word is taken until it is through.
// matrix words outside the rows or columns in use are taken and dropped.
// the word at the last row and last column starts the result run: one word
// per column in use, in column order, each held until the out side takes it
// and last_result high on the final one; the accumulators restart from
// zero afterwards. no input word is taken during a result run. configuration
// writes are taken in any cycle (cfg_ready is always high) and should only be
// issued while the block is idle: index 0 is rows_in_use, index 1 is
// cols_in_use; out of range sizes are clamped. accumulators are zero after
// reset without any clearing pass.
module vector_matrix_multiply
  import vmm_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input word channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  // result word channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  // config writes never stall
  assign cfg_ready = 1'b1;

  // sequencing: accept, read, multiply, accumulate, result run
  vmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and arithmetic
  vmm_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_data  (in_data),
    .cfg_we   (cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule
